/* hdl/tmss_pkg.sv */
// Package for the TeX math source screen: verdict codes, scanner modes,
// event codes and the command denylist match function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tmss_pkg;

  localparam int unsigned CmdChars = 15;
  localparam int unsigned CmdIdxW  = $clog2(CmdChars);

  typedef enum logic [2:0] {
    VerdictAllowed = 3'd0,
    VerdictInvalid = 3'd1,
    VerdictTokens  = 3'd2,
    VerdictDepth   = 3'd3,
    VerdictDenied  = 3'd4
  } verdict_e;

  typedef enum logic [1:0] {
    TokIdle  = 2'd0,
    TokSlash = 2'd1,
    TokWord  = 2'd2
  } tok_mode_e;

  typedef enum logic [1:0] {
    EvNone    = 2'd0,
    EvControl = 2'd1,
    EvDepth   = 2'd2
  } scan_event_e;

  typedef enum logic [1:0] {
    RegMaxBytes  = 2'd0,
    RegMaxTokens = 2'd1,
    RegMaxDepth  = 2'd2
  } cfg_reg_e;

  typedef logic [CmdChars-1:0][6:0] cmd_buf_t;

  function automatic logic word_is(input cmd_buf_t c, input logic [4:0] len,
                                   input logic [8*15-1:0] w, input int unsigned n);
    logic m;
    m = (len == 5'(n));
    for (int i = 0; i < 15; i++) begin
      if (i < n && c[i] != w[8*(n-1-i) +: 7]) m = 1'b0;
    end
    return m;
  endfunction

  function automatic logic cmd_denied(input cmd_buf_t c, input logic [4:0] len);
    logic d;
    d = (len >= 5'd4) && c[0] == 7'h68 && c[1] == 7'h74 && c[2] == 7'h6d && c[3] == 7'h6c;
    d |= word_is(c, len, 120'("href"), 4);
    d |= word_is(c, len, 120'("url"), 3);
    d |= word_is(c, len, 120'("includegraphics"), 15);
    d |= word_is(c, len, 120'("def"), 3);
    d |= word_is(c, len, 120'("gdef"), 4);
    d |= word_is(c, len, 120'("edef"), 4);
    d |= word_is(c, len, 120'("xdef"), 4);
    d |= word_is(c, len, 120'("let"), 3);
    d |= word_is(c, len, 120'("futurelet"), 9);
    d |= word_is(c, len, 120'("newcommand"), 10);
    d |= word_is(c, len, 120'("renewcommand"), 12);
    d |= word_is(c, len, 120'("providecommand"), 14);
    d |= word_is(c, len, 120'("global"), 6);
    d |= word_is(c, len, 120'("csname"), 6);
    d |= word_is(c, len, 120'("endcsname"), 9);
    d |= word_is(c, len, 120'("expandafter"), 11);
    d |= word_is(c, len, 120'("noexpand"), 8);
    return d;
  endfunction

endpackage
`default_nettype wire

/* hdl/tex_math_source_screen.sv */
// Top level of the TeX math source screen: byte scanner and verdict register.
// Depends on tmss_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Takes one source byte per cycle while ready_o is high and gives one verdict
// on the byte marked last; all checks update per byte in a single registered
// stage, and the verdict register is loaded as the last byte is taken; input
// stalls only while a verdict waits and the next last byte arrives.
module tex_math_source_screen (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       is_last_i,
  input  wire logic       is_empty_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output logic [2:0]      verdict_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [15:0] max_bytes_q;
  logic [11:0] max_tok_q;
  logic [7:0]  max_depth_q;
  logic [16:0] bytes_q, bytes_d;
  logic [1:0]  u_pend_q, u_pend_d;
  logic [2:0]  u_cls_q, u_cls_d;
  logic        u_brk_q, u_brk_d;
  logic [12:0] tok_q, tok_d;
  tmss_pkg::tok_mode_e mode_q, mode_d;
  logic [1:0]  skip_q, skip_d;
  logic        esc_q, esc_d;
  logic [7:0]  depth_q, depth_d;
  tmss_pkg::scan_event_e ev_q, ev_d;
  tmss_pkg::cmd_buf_t cmd_q, cmd_d;
  logic [4:0]  clen_q, clen_d;
  logic        den_q, den_d;
  logic        out_v_q;
  logic [2:0]  verdict_q, verdict_d;

  logic [7:0] b;
  logic acc, word_ch, u_ok, fin;
  logic [1:0] lead;
  logic [7:0] lc;

  assign b = data_byte_i;
  assign ready_o = !out_v_q || ready_i || !is_last_i;
  assign acc = valid_i && ready_o;
  assign valid_o = out_v_q;
  assign verdict_o = verdict_q;
  assign word_ch = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h40;
  assign lc = (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;

  always_comb begin
    lead = !b[7] ? 2'd0 : (b[7:5] == 3'b110) ? 2'd1 : (b[7:4] == 4'b1110) ? 2'd2 : 2'd3;
    unique case (u_cls_q)
      3'd1: u_ok = b >= 8'ha0 && b <= 8'hbf;
      3'd2: u_ok = b >= 8'h80 && b <= 8'h9f;
      3'd3: u_ok = b >= 8'h90 && b <= 8'hbf;
      3'd4: u_ok = b >= 8'h80 && b <= 8'h8f;
      default: u_ok = b >= 8'h80 && b <= 8'hbf;
    endcase
  end

  always_comb begin
    bytes_d = (bytes_q != 17'h1ffff) ? bytes_q + 17'd1 : bytes_q;
    u_pend_d = u_pend_q; u_cls_d = u_cls_q; u_brk_d = u_brk_q;
    tok_d = tok_q; mode_d = mode_q; skip_d = skip_q;
    esc_d = esc_q; depth_d = depth_q; ev_d = ev_q;
    cmd_d = cmd_q; clen_d = clen_q; den_d = den_q;
    fin = 1'b0;
    // utf-8
    if (u_pend_q != 2'd0) begin
      u_cls_d = 3'd0;
      if (u_ok) u_pend_d = u_pend_q - 2'd1;
      else begin u_brk_d = 1'b1; u_pend_d = 2'd0; end
    end else if (b >= 8'h80) begin
      if (b >= 8'hc2 && b <= 8'hdf) begin u_pend_d = 2'd1; u_cls_d = 3'd0; end
      else if (b == 8'he0) begin u_pend_d = 2'd2; u_cls_d = 3'd1; end
      else if (b == 8'hed) begin u_pend_d = 2'd2; u_cls_d = 3'd2; end
      else if (b >= 8'he1 && b <= 8'hef) begin u_pend_d = 2'd2; u_cls_d = 3'd0; end
      else if (b == 8'hf0) begin u_pend_d = 2'd3; u_cls_d = 3'd3; end
      else if (b >= 8'hf1 && b <= 8'hf3) begin u_pend_d = 2'd3; u_cls_d = 3'd0; end
      else if (b == 8'hf4) begin u_pend_d = 2'd3; u_cls_d = 3'd4; end
      else u_brk_d = 1'b1;
    end
    // tokens and commands
    if (skip_q != 2'd0) skip_d = skip_q - 2'd1;
    else if (mode_q == tmss_pkg::TokSlash) begin
      if (word_ch) begin
        mode_d = tmss_pkg::TokWord;
        cmd_d[0] = lc[6:0];
        clen_d = 5'd1;
      end else begin
        skip_d = lead; mode_d = tmss_pkg::TokIdle;
      end
    end else if (mode_q == tmss_pkg::TokWord && word_ch) begin
      if (clen_q < 5'(tmss_pkg::CmdChars)) cmd_d[clen_q[tmss_pkg::CmdIdxW-1:0]] = lc[6:0];
      if (clen_q != 5'd31) clen_d = clen_q + 5'd1;
    end else begin
      if (mode_q == tmss_pkg::TokWord) begin
        fin = 1'b1; mode_d = tmss_pkg::TokIdle; clen_d = 5'd0;
      end
      if (!(b == 8'h20 || (b >= 8'h09 && b <= 8'h0d))) begin
        if (tok_q != 13'h1fff) tok_d = tok_q + 13'd1;
        if (b == 8'h5c) mode_d = tmss_pkg::TokSlash;
        else skip_d = lead;
      end
    end
    if (fin && tmss_pkg::cmd_denied(cmd_q, clen_q)) den_d = 1'b1;
    // control bytes and braces
    if (esc_q) esc_d = 1'b0;
    else begin
      if (((b < 8'h20) && b != 8'h0a && b != 8'h09) || b == 8'h7f) begin
        if (ev_q == tmss_pkg::EvNone) ev_d = tmss_pkg::EvControl;
      end
      if (b == 8'h5c) esc_d = 1'b1;
      else if (b == 8'h7b) begin
        if ({1'b0, depth_q} + 9'd1 > {1'b0, max_depth_q} && ev_d == tmss_pkg::EvNone)
          ev_d = tmss_pkg::EvDepth;
        if (depth_q != 8'hff) depth_d = depth_q + 8'd1;
      end else if (b == 8'h7d && depth_q != 8'd0) depth_d = depth_q - 8'd1;
    end
    if (mode_d == tmss_pkg::TokWord && is_last_i &&
        tmss_pkg::cmd_denied(cmd_d, clen_d)) den_d = 1'b1;
    if (is_empty_i) verdict_d = tmss_pkg::VerdictInvalid;
    else if (u_brk_d || u_pend_d != 2'd0 || bytes_d > {1'b0, max_bytes_q})
      verdict_d = tmss_pkg::VerdictInvalid;
    else if (tok_d > {1'b0, max_tok_q}) verdict_d = tmss_pkg::VerdictTokens;
    else if (ev_d == tmss_pkg::EvControl) verdict_d = tmss_pkg::VerdictInvalid;
    else if (ev_d == tmss_pkg::EvDepth) verdict_d = tmss_pkg::VerdictDepth;
    else if (den_d) verdict_d = tmss_pkg::VerdictDenied;
    else verdict_d = tmss_pkg::VerdictAllowed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= 16'd16384; max_tok_q <= 12'd1024; max_depth_q <= 8'd32;
      bytes_q <= '0; u_pend_q <= '0; u_cls_q <= '0; u_brk_q <= 1'b0;
      tok_q <= '0; mode_q <= tmss_pkg::TokIdle; skip_q <= '0; esc_q <= 1'b0;
      depth_q <= '0; ev_q <= tmss_pkg::EvNone; clen_q <= '0; den_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tmss_pkg::RegMaxBytes:  max_bytes_q <= cfg_data_i;
          tmss_pkg::RegMaxTokens: max_tok_q <= cfg_data_i[11:0];
          tmss_pkg::RegMaxDepth:  max_depth_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (acc && is_last_i) out_v_q <= 1'b1;
      else if (ready_i) out_v_q <= 1'b0;
      if (acc) begin
        if (is_last_i) begin
          bytes_q <= '0; u_pend_q <= '0; u_cls_q <= '0; u_brk_q <= 1'b0;
          tok_q <= '0; mode_q <= tmss_pkg::TokIdle; skip_q <= '0; esc_q <= 1'b0;
          depth_q <= '0; ev_q <= tmss_pkg::EvNone; clen_q <= '0; den_q <= 1'b0;
        end else begin
          bytes_q <= bytes_d; u_pend_q <= u_pend_d; u_cls_q <= u_cls_d;
          u_brk_q <= u_brk_d; tok_q <= tok_d; mode_q <= mode_d; skip_q <= skip_d;
          esc_q <= esc_d; depth_q <= depth_d; ev_q <= ev_d; clen_q <= clen_d;
          den_q <= den_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q <= cmd_d;
      if (is_last_i) verdict_q <= verdict_d;
    end
  end

endmodule
`default_nettype wire
